// ----- hw/rtl/h4f_pkg.sv -----
// ----------------------------------------------------------------------------
// h4f_pkg
// Shared types and codes for the HCI H4 packet framer: frame phases, packet
// kind codes, type byte values, header geometry and the per-byte result.
// ----------------------------------------------------------------------------
package h4f_pkg;

	// Framing phase; the fourth code is unused and behaves as idle
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	// Packet kind codes as seen on the output
	localparam logic [1:0] KIND_CMD = 2'd0;
	localparam logic [1:0] KIND_ACL = 2'd1;
	localparam logic [1:0] KIND_SCO = 2'd2;
	localparam logic [1:0] KIND_ISO = 2'd3;

	// H4 type byte values
	localparam logic [7:0] TYPE_CMD = 8'h01;
	localparam logic [7:0] TYPE_ACL = 8'h02;
	localparam logic [7:0] TYPE_SCO = 8'h03;
	localparam logic [7:0] TYPE_ISO = 8'h05;

	// Header geometry, counted in header bytes after the type byte
	localparam logic [2:0] HDR_LEN_SHORT = 3'd3;
	localparam logic [2:0] HDR_LEN_LONG  = 3'd4;
	localparam logic [2:0] LEN_LO_POS    = 3'd3;
	localparam logic [2:0] LEN_HI_POS    = 3'd4;

	// Result of framing one item
	typedef struct packed {
		logic       emit;
		logic [7:0] out_byte;
		logic [1:0] packet_kind;
		logic       first_mark;
		logic       last_mark;
	} frame_res_t;

endpackage

// ----- hw/rtl/h4f_byte_if.sv -----
// ----------------------------------------------------------------------------
// h4f_byte_if
// Valid/ready channel carrying one byte of the host stream per item.
// ----------------------------------------------------------------------------
interface h4f_byte_if;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);

endinterface

// ----- hw/rtl/h4f_frame_if.sv -----
// ----------------------------------------------------------------------------
// h4f_frame_if
// Valid/ready channel carrying one framed byte with its kind and marks.
// ----------------------------------------------------------------------------
interface h4f_frame_if;

	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] packet_kind;
	logic       first_mark;
	logic       last_mark;

	modport source (output valid, output out_byte, output packet_kind,
		output first_mark, output last_mark, input ready);
	modport sink   (input valid, input out_byte, input packet_kind,
		input first_mark, input last_mark, output ready);

endinterface

// ----- hw/rtl/hci_h4_packet_framer.sv -----
// ----------------------------------------------------------------------------
// hci_h4_packet_framer
// Frames a host byte stream into HCI H4 packets, tagging each byte with its
// packet kind and first/last marks. Unknown type bytes are dropped.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, framed by the
// controller and loaded into the result register that drives the output.
// Throughput: one byte per cycle, set by the input register and result
// register handing over in the same cycle while the output is taken.
// Reset: asynchronous, clears the framing state to idle and empties both
// registers; the input is ready as soon as reset is released.
module hci_h4_packet_framer import h4f_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	h4f_byte_if.sink    byte_in,
	h4f_frame_if.source frame_out
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	frame_res_t res;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] out_kind_q;
	logic       out_first_q;
	logic       out_last_q;

	// Move on whenever the result register is free or being taken
	assign advance       = !out_valid_q || frame_out.ready;
	assign byte_in.ready = !valid_s1 || advance;

	// Hold the accepted item in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.data_byte;
		end
	end

	h4f_frame_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && advance),
		.data_byte (byte_s1),
		.res       (res)
	);

	// Load the result register; dropped items leave it empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.emit) begin
			out_byte_q  <= res.out_byte;
			out_kind_q  <= res.packet_kind;
			out_first_q <= res.first_mark;
			out_last_q  <= res.last_mark;
		end
	end

	assign frame_out.valid       = out_valid_q;
	assign frame_out.out_byte    = out_byte_q;
	assign frame_out.packet_kind = out_kind_q;
	assign frame_out.first_mark  = out_first_q;
	assign frame_out.last_mark   = out_last_q;

endmodule

// ----- hw/rtl/h4f_frame_ctrl.sv -----
// ----------------------------------------------------------------------------
// h4f_frame_ctrl
// Framing state and the single-pass decision for one byte: type decode,
// header counting, length capture and payload countdown.
// ----------------------------------------------------------------------------
module h4f_frame_ctrl import h4f_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	output frame_res_t res
);

	phase_t      phase_q,   phase_d;
	logic [1:0]  kind_q,    kind_d;
	logic [2:0]  hpos_q,    hpos_d;
	logic [15:0] plen_q,    plen_d;
	logic [15:0] remain_q,  remain_d;

	logic [2:0]  pos;
	logic [2:0]  hdr_size;
	logic [15:0] remain_dec;

	// Decide the result and next state for the byte at hand
	always_comb begin
		phase_d    = phase_q;
		kind_d     = kind_q;
		hpos_d     = hpos_q;
		plen_d     = plen_q;
		remain_d   = remain_q;
		pos        = hpos_q + 3'd1;
		hdr_size   = ((kind_q == KIND_ACL) || (kind_q == KIND_ISO)) ?
			HDR_LEN_LONG : HDR_LEN_SHORT;
		remain_dec = remain_q - 16'd1;

		res.emit        = 1'b1;
		res.out_byte    = data_byte;
		res.packet_kind = kind_q;
		res.first_mark  = 1'b0;
		res.last_mark   = 1'b0;

		case (phase_q)
			PH_HEADER: begin
				// Capture the length field, little-endian
				if (pos == LEN_LO_POS) begin
					plen_d = {8'h00, data_byte};
				end else if (pos == LEN_HI_POS) begin
					plen_d = {data_byte, plen_q[7:0]};
				end
				hpos_d = pos;
				if (pos >= hdr_size) begin
					if (plen_d == 16'd0) begin
						res.last_mark = 1'b1;
						phase_d       = PH_IDLE;
						hpos_d        = 3'd0;
						remain_d      = 16'd0;
					end else begin
						remain_d = plen_d;
						phase_d  = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				// Count down the payload
				remain_d      = remain_dec;
				res.last_mark = (remain_dec == 16'd0);
				if (remain_dec == 16'd0) begin
					phase_d = PH_IDLE;
					hpos_d  = 3'd0;
				end
			end
			default: begin
				// Expect a type byte; drop anything unknown
				res.first_mark = 1'b1;
				hpos_d         = 3'd0;
				plen_d         = 16'd0;
				remain_d       = 16'd0;
				phase_d        = PH_HEADER;
				case (data_byte)
					TYPE_CMD: kind_d = KIND_CMD;
					TYPE_ACL: kind_d = KIND_ACL;
					TYPE_SCO: kind_d = KIND_SCO;
					TYPE_ISO: kind_d = KIND_ISO;
					default: begin
						res.emit = 1'b0;
						phase_d  = PH_IDLE;
						hpos_d   = hpos_q;
						plen_d   = plen_q;
						remain_d = remain_q;
					end
				endcase
				res.packet_kind = kind_d;
			end
		endcase
	end

	// Advance the framing state on each consumed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			kind_q   <= KIND_CMD;
			hpos_q   <= 3'd0;
			plen_q   <= 16'd0;
			remain_q <= 16'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			kind_q   <= kind_d;
			hpos_q   <= hpos_d;
			plen_q   <= plen_d;
			remain_q <= remain_d;
		end
	end

endmodule

// ----- hw/rtl/h4f_checker.sv -----
// ----------------------------------------------------------------------------
// h4f_checker
// Port-level checks on the framer: reset, output hold, type byte tagging and
// kind continuity within a packet.
// ----------------------------------------------------------------------------
module h4f_checker import h4f_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [1:0] packet_kind,
	input logic       first_mark,
	input logic       last_mark
);

	logic       in_pkt_q;
	logic [1:0] kind_q;
	logic       out_take;

	assign out_take = out_valid && out_ready;

	// Track the packet currently leaving the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pkt_q <= 1'b0;
			kind_q   <= KIND_CMD;
		end else if (out_take) begin
			in_pkt_q <= !last_mark;
			kind_q   <= packet_kind;
		end
	end

	// No result shows during reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(packet_kind) && $stable(first_mark) && $stable(last_mark))
		else $error("stalled result changed");

	// A type byte carries the kind it names and never closes a packet
	a_type_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_mark |-> !last_mark && (
		(out_byte == TYPE_CMD && packet_kind == KIND_CMD) ||
		(out_byte == TYPE_ACL && packet_kind == KIND_ACL) ||
		(out_byte == TYPE_SCO && packet_kind == KIND_SCO) ||
		(out_byte == TYPE_ISO && packet_kind == KIND_ISO)))
		else $error("type byte tagged wrongly");

	// Packets open with a type byte and keep their kind
	a_kind_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !first_mark |-> in_pkt_q && packet_kind == kind_q)
		else $error("packet kind or framing broken");

	// A type byte only opens a new packet
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_mark |-> !in_pkt_q)
		else $error("type byte inside a packet");

endmodule

bind hci_h4_packet_framer h4f_checker u_h4f_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (frame_out.valid),
	.out_ready   (frame_out.ready),
	.out_byte    (frame_out.out_byte),
	.packet_kind (frame_out.packet_kind),
	.first_mark  (frame_out.first_mark),
	.last_mark   (frame_out.last_mark)
);

// ----- tb/hci_h4_packet_framer_tb.sv -----
// ----------------------------------------------------------------------------
// hci_h4_packet_framer_tb
// Self-checking testbench for the HCI H4 packet framer. A short table of
// directed bytes goes first: unknown types, every packet kind, empty and
// non-empty payloads. Random packet traffic follows, mixed with noise and
// broken packets, plus one long packet whose length needs both length bytes.
// Every byte the block accepts runs through a local framing model. Each framed
// byte that leaves the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module hci_h4_packet_framer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import h4f_pkg::*;

	localparam int STALL_LIMIT     = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_TAIL      = 8;
	localparam int PHASE_TARGET    = 140;
	localparam int DIR_ROWS        = 24;

	// One directed row: the byte, and a typed expectation where it is obvious
	typedef struct packed {
		logic [7:0] stim;
		logic       typed;
		frame_res_t res;
	} dir_row_t;

	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{8'h00,    1'b1, '{1'b0, 8'h00, KIND_CMD, 1'b0, 1'b0}},
		'{8'hFF,    1'b1, '{1'b0, 8'h00, KIND_CMD, 1'b0, 1'b0}},
		'{8'h04,    1'b1, '{1'b0, 8'h00, KIND_CMD, 1'b0, 1'b0}},
		'{TYPE_CMD, 1'b1, '{1'b1, TYPE_CMD, KIND_CMD, 1'b1, 1'b0}},
		'{8'h00,    1'b0, '0},
		'{8'hFF,    1'b0, '0},
		'{8'h00,    1'b1, '{1'b1, 8'h00, KIND_CMD, 1'b0, 1'b1}},
		'{TYPE_SCO, 1'b1, '{1'b1, TYPE_SCO, KIND_SCO, 1'b1, 1'b0}},
		'{8'h12,    1'b0, '0},
		'{8'h34,    1'b0, '0},
		'{8'h02,    1'b0, '0},
		'{8'hAA,    1'b0, '0},
		'{8'h55,    1'b0, '0},
		'{TYPE_ACL, 1'b1, '{1'b1, TYPE_ACL, KIND_ACL, 1'b1, 1'b0}},
		'{8'h01,    1'b0, '0},
		'{8'h02,    1'b0, '0},
		'{8'h01,    1'b0, '0},
		'{8'h00,    1'b0, '0},
		'{8'hFF,    1'b0, '0},
		'{TYPE_ISO, 1'b1, '{1'b1, TYPE_ISO, KIND_ISO, 1'b1, 1'b0}},
		'{8'h00,    1'b0, '0},
		'{8'h00,    1'b0, '0},
		'{8'h00,    1'b0, '0},
		'{8'h00,    1'b1, '{1'b1, 8'h00, KIND_ISO, 1'b0, 1'b1}}
	};

	logic clk;
	logic arst_n;

	h4f_byte_if  byte_ch ();
	h4f_frame_if frame_ch ();

	hci_h4_packet_framer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_ch),
		.frame_out (frame_ch)
	);

	// Framing model state
	phase_t      fr_phase;
	logic [1:0]  fr_kind;
	logic [2:0]  fr_hpos;
	logic [15:0] fr_len;
	logic [15:0] fr_left;

	frame_res_t framed_q [$];
	frame_res_t want;

	int src_idle;
	int snk_idle;
	bit hold_req;
	int mismatches;
	int bytes_sent;
	int framed_cnt;
	int bytes_checked;
	int packets_closed;
	int quiet_cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Frame one byte and advance the model state
	function automatic frame_res_t frame_byte(input logic [7:0] b);
		frame_res_t r;
		logic [2:0] pos;
		logic [2:0] hsize;
		logic [1:0] k;
		r = '0;
		case (fr_phase)
			PH_HEADER: begin
				hsize = (fr_kind == KIND_ACL || fr_kind == KIND_ISO) ? HDR_LEN_LONG
					: HDR_LEN_SHORT;
				pos = fr_hpos + 3'd1;
				if (pos == LEN_LO_POS)
					fr_len = {8'h00, b};
				else if (pos == LEN_HI_POS)
					fr_len = fr_len | {b, 8'h00};
				fr_hpos = pos;
				r = '{1'b1, b, fr_kind, 1'b0, 1'b0};
				if (pos >= hsize) begin
					if (fr_len == 16'd0) begin
						r.last_mark = 1'b1;
						fr_phase = PH_IDLE;
						fr_hpos = 3'd0;
						fr_left = 16'd0;
					end else begin
						fr_left = fr_len;
						fr_phase = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				fr_left = fr_left - 16'd1;
				r = '{1'b1, b, fr_kind, 1'b0, fr_left == 16'd0};
				if (fr_left == 16'd0) begin
					fr_phase = PH_IDLE;
					fr_hpos = 3'd0;
				end
			end
			default: begin
				case (b)
					TYPE_CMD: k = KIND_CMD;
					TYPE_ACL: k = KIND_ACL;
					TYPE_SCO: k = KIND_SCO;
					TYPE_ISO: k = KIND_ISO;
					default: begin
						// drop an unknown type byte, stay idle
						fr_phase = PH_IDLE;
						return r;
					end
				endcase
				fr_kind = k;
				fr_hpos = 3'd0;
				fr_len = 16'd0;
				fr_left = 16'd0;
				fr_phase = PH_HEADER;
				r = '{1'b1, b, k, 1'b1, 1'b0};
			end
		endcase
		return r;
	endfunction

	function automatic logic is_type_byte(input logic [7:0] b);
		return b == TYPE_CMD || b == TYPE_ACL || b == TYPE_SCO || b == TYPE_ISO;
	endfunction

	function automatic logic [7:0] type_byte_of(input logic [1:0] kind);
		case (kind)
			KIND_CMD: return TYPE_CMD;
			KIND_ACL: return TYPE_ACL;
			KIND_SCO: return TYPE_SCO;
			default:  return TYPE_ISO;
		endcase
	endfunction

	// Mostly short payloads, a few long ones; 16-bit lengths rarely past 256
	function automatic logic [15:0] pick_len(input logic [1:0] kind);
		int roll;
		roll = $urandom_range(99);
		if (roll < 15)
			return 16'd0;
		if (roll < 90)
			return 16'($urandom_range(12, 1));
		if (roll < 97)
			return 16'($urandom_range(64, 13));
		if (kind == KIND_ACL || kind == KIND_ISO)
			return 16'($urandom_range(280, 65));
		return 16'($urandom_range(255, 65));
	endfunction

	// Random byte, but keep the length high byte small so packets stay short
	function automatic logic [7:0] stream_byte();
		if (fr_phase == PH_HEADER && fr_hpos + 3'd1 == LEN_HI_POS)
			return 8'($urandom_range(1));
		return 8'($urandom_range(255));
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("MISMATCH at %0t ns: %s got %0h expected %0h", $time, what, got, exp_val);
		mismatches++;
	endtask

	// Offer one item, wait for it to be taken, record what it should produce
	task automatic put_byte(input logic [7:0] b, input logic typed, input frame_res_t typed_res);
		frame_res_t r;
		while ($urandom_range(99) < src_idle) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		r = frame_byte(b);
		if (typed)
			r = typed_res;
		bytes_sent++;
		if (r.emit) begin
			framed_q.push_back(r);
			framed_cnt++;
		end
	endtask

	task automatic send_packet(input logic [1:0] kind, input logic [15:0] len);
		put_byte(type_byte_of(kind), 1'b0, '0);
		put_byte(8'($urandom_range(255)), 1'b0, '0);
		put_byte(8'($urandom_range(255)), 1'b0, '0);
		put_byte(len[7:0], 1'b0, '0);
		if (kind == KIND_ACL || kind == KIND_ISO)
			put_byte(len[15:8], 1'b0, '0);
		for (int i = 0; i < int'(len); i++)
			put_byte(8'($urandom_range(255)), 1'b0, '0);
	endtask

	// Hold the sender until every framed byte has come out
	task automatic hold_until_drained();
		byte_ch.valid <= 1'b0;
		while (framed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// Random traffic: well-formed packets, bursts of junk, broken packets
	task automatic run_traffic(input int target, input bit with_hold);
		int start;
		int roll;
		logic [1:0] kind;
		logic [7:0] b;
		bit held;
		start = framed_cnt;
		held = 1'b0;
		while (framed_cnt - start < target) begin
			if (with_hold && !held && framed_cnt - start > target / 3) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			roll = $urandom_range(99);
			if (roll < 80) begin
				kind = 2'($urandom_range(3));
				send_packet(kind, pick_len(kind));
			end else if (roll < 90) begin
				repeat ($urandom_range(4, 1)) begin
					do b = 8'($urandom_range(255)); while (is_type_byte(b));
					put_byte(b, 1'b0, '0);
				end
			end else begin
				put_byte(type_byte_of(2'($urandom_range(3))), 1'b0, '0);
				repeat ($urandom_range(6, 1))
					put_byte(stream_byte(), 1'b0, '0);
				// resynchronise: finish whatever the junk started
				while (fr_phase != PH_IDLE)
					put_byte(stream_byte(), 1'b0, '0);
			end
		end
	endtask

	// Stimulus
	initial begin
		arst_n = 1'b1;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		fr_phase = PH_IDLE;
		fr_kind = KIND_CMD;
		fr_hpos = 3'd0;
		fr_len = 16'd0;
		fr_left = 16'd0;
		hold_req = 1'b0;
		src_idle = 0;
		snk_idle = 0;
		mismatches = 0;
		bytes_sent = 0;
		framed_cnt = 0;
		// Assert reset once every process is waiting on it
		#1 arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table
		src_idle = 20;
		snk_idle = 20;
		for (int i = 0; i < DIR_ROWS; i++)
			put_byte(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].res);
		hold_until_drained();

		// Sender busier than receiver, with one long receiver hold-off
		src_idle = 35;
		snk_idle = 45;
		run_traffic(PHASE_TARGET, 1'b1);
		hold_until_drained();

		// Receiver busier than sender
		src_idle = 45;
		snk_idle = 35;
		run_traffic(PHASE_TARGET, 1'b0);
		hold_until_drained();

		// Full rate, including one packet with a non-zero length high byte
		src_idle = 0;
		snk_idle = 0;
		send_packet(KIND_ACL, 16'h0100);
		run_traffic(PHASE_TARGET, 1'b0);
		hold_until_drained();

		$display("Sent %0d bytes, %0d framed bytes checked across %0d packets",
			bytes_sent, bytes_checked, packets_closed);
		$display("Covered all four kinds, junk, broken packets, a 256-byte payload and back-pressure");
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		frame_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				frame_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
				frame_ch.ready <= 1'b0;
			end else begin
				frame_ch.ready <= ($urandom_range(99) >= snk_idle);
			end
		end
	end

	// Compare each framed item with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			if (framed_q.size() == 0) begin
				report_mismatch("unexpected framed byte", frame_ch.out_byte, 0);
			end else begin
				want = framed_q.pop_front();
				if (frame_ch.out_byte !== want.out_byte)
					report_mismatch("out_byte", frame_ch.out_byte, want.out_byte);
				if (frame_ch.packet_kind !== want.packet_kind)
					report_mismatch("packet_kind", frame_ch.packet_kind, want.packet_kind);
				if (frame_ch.first_mark !== want.first_mark)
					report_mismatch("first_mark", frame_ch.first_mark, want.first_mark);
				if (frame_ch.last_mark !== want.last_mark)
					report_mismatch("last_mark", frame_ch.last_mark, want.last_mark);
				bytes_checked++;
				if (want.last_mark)
					packets_closed++;
			end
		end
	end

	// Watchdog: end the run if neither side moves for too long
	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) || (frame_ch.valid && frame_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout after %0d quiet cycles", quiet_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule
